>>> rtl/lmsmc_pkg.sv
// Shared types, field widths and codes for the LRU multi-size miss counter.
`default_nettype none

package lmsmc_pkg;

  // Field widths fixed by the request and result formats.
  localparam int ADDR_W     = 24;
  localparam int CNT_W      = 32;
  localparam int SIZE_W     = 9;
  localparam int CCNT_W     = 3;
  localparam int OIDX_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // At most this many counts leave in one report.
  localparam int MAX_OUT = 4;

  // Defaults for the top-level parameters.
  localparam int DEF_STACK_DEPTH = 256;
  localparam int DEF_NUM_SIZES   = 4;

  // Reset value of the cache count register.
  localparam logic [CCNT_W-1:0] CACHE_COUNT_RESET = 3'd4;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_CACHE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_0      = 3'd1;

  // Request kinds carried in tuser.
  localparam logic ACT_ACCESS = 1'b0;
  localparam logic ACT_REPORT = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ENC,
    ST_UPD,
    ST_RPT
  } state_t;

  // Controls from the sequencer to every stack cell.
  typedef struct packed {
    logic cmp;
    logic upd;
  } cell_ctl_t;

  // Controls from the sequencer to the counter bank.
  typedef struct packed {
    logic upd;
    logic clr;
  } cnt_ctl_t;

endpackage

`default_nettype wire

>>> rtl/lmsmc_cell.sv
// One entry of the LRU stack: address, valid bit and match flag.
`default_nettype none

module lmsmc_cell
  import lmsmc_pkg::*;
#(
  parameter int          PW  = 8,
  parameter int unsigned IDX = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cell_ctl_t         ctl,
  input  wire logic [ADDR_W-1:0] cmp_addr,
  input  wire logic [PW-1:0]     pos,
  input  wire logic [ADDR_W-1:0] up_addr,
  input  wire logic              up_valid,
  output logic      [ADDR_W-1:0] addr,
  output logic                   valid,
  output logic                   match
);

  logic [ADDR_W-1:0] addr_r;
  logic              valid_r;
  logic              match_r;
  logic              shift;

  // Entries at or above the hit position take their upper neighbor.
  assign shift = ctl.upd && (PW'(IDX) <= pos);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      addr_r <= up_addr;
    end
  end

  // Compare against the incoming address when an access request is taken.
  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      match_r <= valid_r && (addr_r == cmp_addr);
    end
  end

  assign addr  = addr_r;
  assign valid = valid_r;
  assign match = match_r;

endmodule

`default_nettype wire

>>> rtl/lmsmc_enc.sv
// Turns the one-hot match row of the stack into a registered position.
`default_nettype none

module lmsmc_enc
  import lmsmc_pkg::*;
#(
  parameter int DEPTH = DEF_STACK_DEPTH,
  parameter int PW    = $clog2(DEF_STACK_DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [DEPTH-1:0] match,
  output logic      [PW-1:0]    pos,
  output logic                  found
);

  logic [PW-1:0] pos_r;
  logic [PW-1:0] pos_nxt;
  logic          found_r;
  logic          found_nxt;

  // At most one entry matches, so OR-ing the indexes gives its position.
  // A miss reports the bottom entry so that the whole stack shifts.
  always_comb begin
    logic [PW-1:0] enc;
    enc       = '0;
    found_nxt = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match[i]) begin
        enc       = enc | PW'(i);
        found_nxt = 1'b1;
      end
    end
    pos_nxt = found_nxt ? enc : PW'(DEPTH - 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_r   <= pos_nxt;
      found_r <= found_nxt;
    end
  end

  assign pos   = pos_r;
  assign found = found_r;

endmodule

`default_nettype wire

>>> rtl/lmsmc_cnt.sv
// Configuration registers and saturating miss counters, one per cache size.
`default_nettype none

module lmsmc_cnt
  import lmsmc_pkg::*;
#(
  parameter int NC = DEF_NUM_SIZES,
  parameter int PW = $clog2(DEF_STACK_DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire cnt_ctl_t              ctl,
  input  wire logic                  found,
  input  wire logic [PW-1:0]         pos,
  input  wire logic [OIDX_W-1:0]     rd_idx,
  output logic      [CNT_W-1:0]      rd_count,
  output logic      [CCNT_W-1:0]     act_n
);

  localparam int CW = (PW > SIZE_W) ? PW : SIZE_W;

  logic [CCNT_W-1:0] cache_count_r;
  logic [SIZE_W-1:0] size_r [NC];
  logic [CNT_W-1:0]  cnt_r  [NC];

  // Number of caches in use, limited to the counters present.
  assign act_n = (cache_count_r > CCNT_W'(NC)) ? CCNT_W'(NC) : cache_count_r;

  // Cache count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_count_r <= CACHE_COUNT_RESET;
    end else if (cfg_we && (cfg_index == CFG_CACHE_COUNT)) begin
      cache_count_r <= cfg_wdata[CCNT_W-1:0];
    end
  end

  // Size registers and counters, one set per cache.
  for (genvar k = 0; k < NC; k++) begin : g_cache
    logic miss;

    // A cache misses when the address is absent or sits at or below its size.
    assign miss = !found || (CW'(pos) >= CW'(size_r[k]));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        size_r[k] <= SIZE_W'(1) << k;
      end else if (cfg_we && (cfg_index == CFG_SIZE_0 + CFG_IDX_W'(k))) begin
        size_r[k] <= cfg_wdata[SIZE_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cnt_r[k] <= '0;
      end else if (ctl.clr) begin
        cnt_r[k] <= '0;
      end else if (ctl.upd && miss && (CCNT_W'(k) < act_n) && (cnt_r[k] != '1)) begin
        cnt_r[k] <= cnt_r[k] + CNT_W'(1);
      end
    end
  end

  // Read port for the report sequence.
  always_comb begin
    rd_count = '0;
    for (int k = 0; k < NC; k++) begin
      if (rd_idx == OIDX_W'(k)) begin
        rd_count = cnt_r[k];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/lru_multi_size_miss_counter_unit.sv
// Top level of the LRU stack-distance miss counter for several cache sizes.
//
// The block keeps a chain of STACK_DEPTH cells holding the most recently used
// addresses, newest in cell 0, and counts misses for up to four fully
// associative LRU caches at once. For an access request (tuser 0), every
// cell compares its address with the request at the accept edge, the
// one-hot match row is encoded to a stack position in the next cycle,
// and in state ST_UPD the cells from cell 0 down to the hit shift down
// by one while the counters of all caches no larger than that position advance.
// A report request (tuser 1) sends one saturating count per cache in use,
// in register order, through a single output register (one count per cycle
// while the sink is ready) and clears the counters after the last one; with a
// cache count of zero it only clears them and sends nothing. The
// input stays ready again as soon as the last count sits in the output
// register. Configuration writes must be made only while no request is in work.
`default_nettype none

module lru_multi_size_miss_counter_unit
  import lmsmc_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int NUM_SIZES   = DEF_NUM_SIZES
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Request channel.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [ADDR_W-1:0]     in_tdata,   // [23:0] address
  input  wire logic                  in_tuser,   // [0] action
  // Result channel.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [CNT_W-1:0]      out_tdata,  // [31:0] miss_count
  output logic      [OIDX_W-1:0]     out_tuser,  // [1:0] cache_index
  output logic                       out_tlast,
  // Configuration write port.
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PW = $clog2(STACK_DEPTH);
  localparam int NC = (NUM_SIZES < MAX_OUT) ? NUM_SIZES : MAX_OUT;

  state_t             state_r;
  state_t             state_nxt;
  logic [ADDR_W-1:0]  addr_r;
  logic [OIDX_W-1:0]  rpt_idx_r;
  logic               out_tvalid_r;
  logic [CNT_W-1:0]   out_tdata_r;
  logic [OIDX_W-1:0]  out_tuser_r;
  logic               out_tlast_r;

  logic               acc;
  logic               enc_en;
  logic               out_free;
  logic               out_load;
  logic               rpt_empty;
  logic               rpt_last;
  cell_ctl_t          cell_ctl;
  cnt_ctl_t           cnt_ctl;

  logic [ADDR_W-1:0]  cell_addr  [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] cell_valid;
  logic [STACK_DEPTH-1:0] match_vec;
  logic [PW-1:0]      pos;
  logic               found;
  logic [CNT_W-1:0]   rd_count;
  logic [CCNT_W-1:0]  act_n;

  // Sequencer outputs.
  always_comb begin
    in_tready    = (state_r == ST_IDLE);
    acc          = in_tvalid && in_tready;
    cell_ctl.cmp = acc && (in_tuser == ACT_ACCESS);
    cell_ctl.upd = (state_r == ST_UPD);
    enc_en       = (state_r == ST_ENC);
    cnt_ctl.upd  = (state_r == ST_UPD);
    rpt_empty    = (act_n == '0);
    out_free     = !out_tvalid_r || out_tready;
    rpt_last     = ({1'b0, rpt_idx_r} + CCNT_W'(1)) == act_n;
    out_load     = (state_r == ST_RPT) && !rpt_empty && out_free;
    cnt_ctl.clr  = (state_r == ST_RPT) && (rpt_empty || (out_free && rpt_last));
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          state_nxt = (in_tuser == ACT_ACCESS) ? ST_ENC : ST_RPT;
        end
      end
      ST_ENC: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        state_nxt = ST_IDLE;
      end
      ST_RPT: begin
        if (cnt_ctl.clr) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rpt_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (acc) begin
        rpt_idx_r <= '0;
      end else if (out_load) begin
        rpt_idx_r <= rpt_idx_r + OIDX_W'(1);
      end
    end
  end

  // Address of the access in work, pushed into cell 0 on update.
  always_ff @(posedge clk) begin
    if (acc) begin
      addr_r <= in_tdata;
    end
  end

  // Chain of stack cells.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [ADDR_W-1:0] up_addr;
    logic              up_valid;

    if (i == 0) begin : g_top
      assign up_addr  = addr_r;
      assign up_valid = 1'b1;
    end else begin : g_rest
      assign up_addr  = cell_addr[i-1];
      assign up_valid = cell_valid[i-1];
    end

    lmsmc_cell #(
      .PW  (PW),
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cell_ctl),
      .cmp_addr (in_tdata),
      .pos      (pos),
      .up_addr  (up_addr),
      .up_valid (up_valid),
      .addr     (cell_addr[i]),
      .valid    (cell_valid[i]),
      .match    (match_vec[i])
    );
  end

  lmsmc_enc #(
    .DEPTH (STACK_DEPTH),
    .PW    (PW)
  ) u_enc (
    .clk   (clk),
    .en    (enc_en),
    .match (match_vec),
    .pos   (pos),
    .found (found)
  );

  lmsmc_cnt #(
    .NC (NC),
    .PW (PW)
  ) u_cnt (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ctl       (cnt_ctl),
    .found     (found),
    .pos       (pos),
    .rd_idx    (rpt_idx_r),
    .rd_count  (rd_count),
    .act_n     (act_n)
  );

  // Output register for report counts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= rd_count;
      out_tuser_r <= rpt_idx_r;
      out_tlast_r <= rpt_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  // An update always follows an encode cycle.
  a_upd_after_enc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> ($past(state_r) == ST_ENC))
    else $error("stack update without a preceding encode");

  // An address is held in at most one valid cell.
  a_match_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    enc_en |-> $onehot0(match_vec))
    else $error("address found in more than one stack cell");

  // The last count of a report belongs to the last cache in use.
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (({1'b0, out_tuser} + CCNT_W'(1)) == act_n))
    else $error("report ended on the wrong cache");

  // Counts of one report follow each other in cache order without a gap.
  a_report_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (out_tvalid && (out_tuser == $past(out_tuser) + OIDX_W'(1))))
    else $error("report counts out of order");

endmodule

`default_nettype wire
